@@ sv/sldf_pkg.sv @@
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies.
package sldf_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SYNC_WORD = 1'd0,
    CFG_MAX_LEN   = 1'd1
  } cfg_index_t;

  localparam logic [31:0] SYNC_WORD_RESET = 32'h524D_4354;
  localparam logic [6:0]  MAX_LEN_RESET   = 7'd126;
  localparam logic [7:0]  MIN_LEN         = 8'd2;
  localparam logic [7:0]  CLEN_XOR        = 8'hFF;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BAD_LEN  = 3'd2,
    KIND_BAD_CLEN = 3'd3,
    KIND_BAD_SUM  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [6:0] position;
    logic       frame_end;
  } result_t;

endpackage

@@ sv/sync_length_checksum_deframer.sv @@
// Sync-word / length / checksum deframer, top level.
// Depends on sldf_pkg.
// A result is registered in out_r, or in skid_r while out_* is stalled.
// Throughput: one byte per cycle while in_stall is low; a two-entry output stage (register + skid)
// lets input continue while a result waits, in_stall is the skid-full flag.
// Reset (synchronous, rst_n low): hunt for first sync byte, output empty,
// registers back to their defaults.
module sync_length_checksum_deframer #(
  parameter int unsigned FRAME_BUFFER_BYTES = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sldf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sldf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_kind,
  output logic [7:0]                         out_data_byte,
  output logic [6:0]                         out_position,
  output logic                               out_frame_end
);
  import sldf_pkg::*;

  localparam logic [8:0] LEN_LIMIT = 9'(FRAME_BUFFER_BYTES - 2);

  typedef enum logic [2:0] {
    PH_SYNC0   = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_SYNC2   = 3'd2,
    PH_SYNC3   = 3'd3,
    PH_LEN     = 3'd4,
    PH_CLEN    = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_SUM     = 3'd7
  } phase_t;

  logic [31:0] sync_word_r;
  logic [6:0]  max_len_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [6:0]  count_r, count_nxt;

  result_t     out_r, skid_r, res;
  logic        out_valid_r, skid_valid_r;
  logic        res_valid;
  logic        in_fire, out_fire;
  logic [7:0]  expect_byte;
  logic [6:0]  count_inc;
  logic [6:0]  need;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_r.kind;
  assign out_data_byte = out_r.data_byte;
  assign out_position  = out_r.position;
  assign out_frame_end = out_r.frame_end;

  assign count_inc = count_r + 7'd1;
  assign need      = len_r - 7'(MIN_LEN);

  always_comb begin
    case (phase_r)
      PH_SYNC0: expect_byte = sync_word_r[31:24];
      PH_SYNC1: expect_byte = sync_word_r[23:16];
      PH_SYNC2: expect_byte = sync_word_r[15:8];
      default:  expect_byte = sync_word_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    sum_nxt   = (phase_r == PH_SYNC0) ? in_rx_byte : sum_r + in_rx_byte;
    res_valid = 1'b0;
    res       = '{kind: KIND_PAYLOAD, data_byte: 8'd0, position: 7'd0, frame_end: 1'b1};
    case (phase_r)
      PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
        phase_nxt = (in_rx_byte == expect_byte) ? phase_t'(phase_r + 3'd1) : PH_SYNC0;
      end
      PH_LEN: begin
        if (in_rx_byte < MIN_LEN || in_rx_byte > {1'b0, max_len_r} ||
            {1'b0, in_rx_byte} > LEN_LIMIT) begin
          phase_nxt = PH_SYNC0;
          res_valid = 1'b1;
          res.kind  = KIND_BAD_LEN;
        end else begin
          len_nxt   = in_rx_byte[6:0];
          phase_nxt = PH_CLEN;
        end
      end
      PH_CLEN: begin
        if ((in_rx_byte ^ {1'b0, len_r}) != CLEN_XOR) begin
          phase_nxt = PH_SYNC0;
          res_valid = 1'b1;
          res.kind  = KIND_BAD_CLEN;
        end else begin
          count_nxt = 7'd0;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        count_nxt     = count_inc;
        if (count_inc >= need) phase_nxt = PH_SUM;
        res_valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = in_rx_byte;
        res.position  = count_r;
        res.frame_end = 1'b0;
      end
      default: begin
        phase_nxt = PH_SYNC0;
        res_valid = 1'b1;
        if (sum_nxt != 8'd0) begin
          res.kind = KIND_BAD_SUM;
        end else begin
          res.kind     = KIND_GOOD;
          res.position = count_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r  <= SYNC_WORD_RESET;
      max_len_r    <= MAX_LEN_RESET;
      phase_r      <= PH_SYNC0;
      sum_r        <= 8'd0;
      len_r        <= 7'd0;
      count_r      <= 7'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_WORD: sync_word_r <= cfg_wdata;
          CFG_MAX_LEN:   max_len_r   <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r <= phase_nxt;
        sum_r   <= sum_nxt;
        len_r   <= len_nxt;
        count_r <= count_nxt;
      end
      if (skid_valid_r) begin
        if (out_fire) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        if (!out_valid_r || out_fire) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ sv/sldf_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
// Depends on sldf_pkg and sync_length_checksum_deframer.
module sldf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_kind,
  input logic [7:0] out_data_byte,
  input logic [6:0] out_position,
  input logic       out_frame_end
);
  import sldf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_end == (out_kind != KIND_PAYLOAD)))
    else $error("frame_end disagrees with kind");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BAD_LEN || out_kind == KIND_BAD_CLEN ||
                  out_kind == KIND_BAD_SUM)
    |-> out_position == 7'd0 && out_data_byte == 8'd0)
    else $error("error verdict carries nonzero fields");

  a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_GOOD |-> out_data_byte == 8'd0 && out_position != 7'd0)
    else $error("good verdict malformed");

endmodule

bind sync_length_checksum_deframer sldf_checker u_sldf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_data_byte (out_data_byte),
  .out_position  (out_position),
  .out_frame_end (out_frame_end)
);

@@ tb/sldf_frame_checker.sv @@
// Result checker for the sync/length/checksum deframer testbench.
// Watches the register port and both channels, predicts each result and compares.
// Depends on sldf_pkg.
module sldf_frame_checker #(
  parameter int unsigned FRAME_BUFFER_BYTES = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sldf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sldf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [2:0]                       out_kind,
  input  logic [7:0]                       out_data_byte,
  input  logic [6:0]                       out_position,
  input  logic                             out_frame_end,
  output int unsigned                      mismatches,
  output int unsigned                      events_outstanding
);
  import sldf_pkg::*;

  typedef enum logic [2:0] {
    HUNT_0, HUNT_1, HUNT_2, HUNT_3, GET_LEN, GET_CLEN, GET_PAYLOAD, GET_CSUM
  } rx_phase_t;

  logic [31:0] sync_copy;
  logic [6:0]  max_len_copy;
  rx_phase_t   rx_phase;
  logic [7:0]  frame_sum;
  logic [6:0]  frame_len;
  logic [6:0]  payload_seen;
  result_t     frame_events_due[$];

  function automatic result_t verdict(input kind_t k, input logic [6:0] pos);
    return '{kind: k, data_byte: 8'd0, position: pos, frame_end: 1'b1};
  endfunction

  task automatic track_rx_byte(input logic [7:0] b);
    logic [6:0] idx;
    logic [6:0] need;
    frame_sum = (rx_phase == HUNT_0) ? b : frame_sum + b;
    case (rx_phase)
      HUNT_0, HUNT_1, HUNT_2, HUNT_3: begin
        if (b == sync_copy[8 * (3 - int'(rx_phase)) +: 8]) begin
          rx_phase = rx_phase_t'(rx_phase + 3'd1);
        end else begin
          rx_phase = HUNT_0;
        end
      end
      GET_LEN: begin
        if (b < MIN_LEN || b > {1'b0, max_len_copy} || 32'(b) > FRAME_BUFFER_BYTES - 2) begin
          rx_phase = HUNT_0;
          frame_events_due.push_back(verdict(KIND_BAD_LEN, 7'd0));
        end else begin
          frame_len = b[6:0];
          rx_phase  = GET_CLEN;
        end
      end
      GET_CLEN: begin
        if ((b ^ {1'b0, frame_len}) != CLEN_XOR) begin
          rx_phase = HUNT_0;
          frame_events_due.push_back(verdict(KIND_BAD_CLEN, 7'd0));
        end else begin
          payload_seen = 7'd0;
          rx_phase     = GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        idx          = payload_seen;
        payload_seen = payload_seen + 7'd1;
        need         = (frame_len >= 7'd2) ? frame_len - 7'd2 : 7'd0;
        if (payload_seen >= need) begin
          rx_phase = GET_CSUM;
        end
        frame_events_due.push_back('{kind: KIND_PAYLOAD, data_byte: b, position: idx,
                                     frame_end: 1'b0});
      end
      default: begin
        rx_phase = HUNT_0;
        if (frame_sum != 8'd0) begin
          frame_events_due.push_back(verdict(KIND_BAD_SUM, 7'd0));
        end else begin
          frame_events_due.push_back(verdict(KIND_GOOD, payload_seen));
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (frame_events_due.size() == 0) begin
      $error("unexpected result: kind %0d data_byte %0d position %0d frame_end %0d",
             out_kind, out_data_byte, out_position, out_frame_end);
      mismatches++;
    end else begin
      want = frame_events_due.pop_front();
      compare_field("kind", want.kind, out_kind);
      compare_field("data_byte", want.data_byte, out_data_byte);
      compare_field("position", want.position, out_position);
      compare_field("frame_end", want.frame_end, out_frame_end);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_copy    = SYNC_WORD_RESET;
      max_len_copy = MAX_LEN_RESET;
      rx_phase     = HUNT_0;
      frame_sum    = 8'd0;
      frame_len    = 7'd0;
      payload_seen = 7'd0;
      frame_events_due.delete();
    end else begin
      // a result leaving at this edge was caused by an earlier transaction
      if (out_valid && !out_stall) begin
        check_result();
      end
      if (in_valid && !in_stall) begin
        track_rx_byte(in_rx_byte);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_WORD: sync_copy = cfg_wdata;
          CFG_MAX_LEN:   max_len_copy = cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
    events_outstanding = frame_events_due.size();
  end

endmodule

@@ tb/tb_sync_length_checksum_deframer.sv @@
// Top of the sync/length/checksum deframer testbench: clock, reset, byte stream
// and register writes; checking is done by sldf_frame_checker.
// Depends on sldf_pkg, sync_length_checksum_deframer and sldf_frame_checker.
module tb_sync_length_checksum_deframer;
  import sldf_pkg::*;

  localparam int unsigned FRAME_BUFFER_BYTES = 128;
  localparam int unsigned CYCLE_LIMIT        = 200000;
  localparam int unsigned DRAIN_CYCLES       = 8;
  localparam int unsigned BYTES_PER_SETTING  = 100;

  typedef logic [7:0] byte_q_t[$];

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = CFG_SYNC_WORD;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_rx_byte = 8'd0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [2:0]             out_kind;
  logic [7:0]             out_data_byte;
  logic [6:0]             out_position;
  logic                   out_frame_end;

  int unsigned mismatches;
  int unsigned events_outstanding;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  bit          pace = 1'b1;
  logic [31:0] sync_now    = SYNC_WORD_RESET;
  logic [6:0]  max_len_now = MAX_LEN_RESET;

  sync_length_checksum_deframer #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_position  (out_position),
    .out_frame_end (out_frame_end)
  );

  sldf_frame_checker #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_position       (out_position),
    .out_frame_end      (out_frame_end),
    .mismatches         (mismatches),
    .events_outstanding (events_outstanding)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= pace && ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sync_length_checksum_deframer test failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] sync, input logic [6:0] mlen);
    write_reg(CFG_SYNC_WORD, sync);
    write_reg(CFG_MAX_LEN, {25'd0, mlen});
    sync_now    = sync;
    max_len_now = mlen;
  endtask

  task automatic push_byte(input logic [7:0] b);
    while (pace && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic push_bytes(input byte_q_t q);
    foreach (q[i]) push_byte(q[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (events_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic byte_q_t rand_payload(input int unsigned n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // sync, length, complement, payload, checksum; cut to the first keep bytes
  function automatic byte_q_t frame_bytes(input logic [7:0] len, input byte_q_t payload,
                                          input bit clen_ok, input bit sum_ok,
                                          input int unsigned keep);
    byte_q_t    q;
    logic [7:0] sum;
    logic [7:0] csum;
    for (int i = 3; i >= 0; i--) q.push_back(sync_now[8*i +: 8]);
    q.push_back(len);
    q.push_back(clen_ok ? ~len : ~len ^ 8'($urandom_range(1, 255)));
    foreach (payload[i]) q.push_back(payload[i]);
    sum = 8'd0;
    foreach (q[i]) sum += q[i];
    csum = 8'd0 - sum;
    q.push_back(sum_ok ? csum : csum ^ 8'($urandom_range(1, 255)));
    while (q.size() > keep) void'(q.pop_back());
    return q;
  endfunction

  task automatic random_frame();
    int unsigned pick;
    int unsigned lmax;
    int unsigned len;
    int unsigned k;
    pick = $urandom_range(0, 99);
    lmax = (max_len_now > 126) ? 126 : max_len_now;
    if (pick < 75 && lmax < 2) pick = 80;
    if (pick < 75) begin
      if ($urandom_range(0, 9) < 8 && lmax > 12) len = $urandom_range(2, 12);
      else len = $urandom_range(2, lmax);
      push_bytes(frame_bytes(8'(len), rand_payload(len > 2 ? len - 2 : 1), pick < 68,
                             pick < 60, pick < 68 ? 255 : 6));
    end else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0:       len = 0;
        1:       len = 1;
        2:       len = 127;
        default: len = $urandom_range(max_len_now + 1, 255);
      endcase
      push_bytes(frame_bytes(8'(len), rand_payload(1), 1'b1, 1'b1, 5));
    end else if (pick < 93) begin
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++) push_byte(sync_now[8*(3-i) +: 8]);
      push_byte(sync_now[8*(3-k) +: 8] ^ 8'($urandom_range(1, 255)));
    end else begin
      push_bytes(rand_payload($urandom_range(1, 4)));
    end
  endtask

  initial begin
    int unsigned start;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values
    push_bytes(frame_bytes(8'd2, '{8'hFF}, 1'b1, 1'b1, 255));
    push_bytes(frame_bytes(8'd0, '{8'h00}, 1'b1, 1'b1, 5));
    push_byte(sync_now[31:24]);
    push_byte(~sync_now[23:16]);
    push_bytes(frame_bytes(8'd3, '{8'h00}, 1'b0, 1'b1, 6));
    push_bytes(frame_bytes(8'd4, '{8'h00, 8'hFF}, 1'b1, 1'b0, 255));
    settle();

    for (int s = 0; s < 6; s++) begin
      case (s)
        0:       apply_setting($urandom, 7'd2);
        1:       apply_setting($urandom, 7'd126);
        2:       apply_setting(32'h0000_0000, 7'd0);
        3:       apply_setting(32'hFFFF_FFFF, 7'd127);
        4:       apply_setting($urandom, 7'($urandom_range(2, 126)));
        default: apply_setting(SYNC_WORD_RESET, MAX_LEN_RESET);
      endcase
      pace  = (s != 5);
      start = bytes_sent;
      while (bytes_sent - start < BYTES_PER_SETTING) random_frame();
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("sync_length_checksum_deframer test passed");
    end else begin
      $display("sync_length_checksum_deframer test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/sldf_pkg.sv
sv/sync_length_checksum_deframer.sv
sv/sldf_checker.sv
tb/sldf_frame_checker.sv
tb/tb_sync_length_checksum_deframer.sv
